FILE: hdl/ieval_pkg.sv
// shared types and constants for the infix expression evaluator
// operator codes, character codes and the control structs of the mul/div unit
// no dependencies
package ieval_pkg;

	localparam int unsigned ValueOutW = 32;

	typedef enum logic [1:0] {
		OP_PLUS  = 2'd0,
		OP_MINUS = 2'd1,
		OP_MUL   = 2'd2,
		OP_DIV   = 2'd3
	} op_t;

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharPlus  = 8'h2b;
	localparam logic [7:0] CharMinus = 8'h2d;
	localparam logic [7:0] CharStar  = 8'h2a;
	localparam logic [7:0] CharSlash = 8'h2f;

	typedef struct packed {
		logic start;
		logic is_div;
	} unit_req_t;

	typedef struct packed {
		logic done;
		logic dbz;
	} unit_rsp_t;

endpackage

FILE: hdl/infix_expression_evaluator_core.sv
// infix expression evaluator: one character per item, result on the last one
// precedence of * and / over + and -, all arithmetic wraps at VALUE_WIDTH bits
// depends on ieval_pkg and ieval_muldiv
// a skipped or digit character that is not last stays in the idle state
// an operator or last character resolving a pending + or - goes through resolve
// and finish, one resolving a pending * or / through resolve, wait and finish
// reset clears all expression state and the output register
module infix_expression_evaluator_core #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value
	output logic        m_tuser    // div_by_zero
);

	localparam int unsigned W = VALUE_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESOLVE,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [W-1:0]         cur_q;
	logic [W-1:0]         term_q;
	logic [W-1:0]         sum_q;
	ieval_pkg::op_t       op_q;
	ieval_pkg::op_t       new_op_q;
	logic                 is_op_q;
	logic                 last_q;
	logic                 err_q;
	logic                 m_tvalid_q;
	logic [31:0]          m_tdata_q;
	logic                 m_tuser_q;

	logic                 accept;
	logic                 in_digit;
	logic                 in_op;
	ieval_pkg::op_t       in_opcode;
	logic [3:0]           digit;
	logic [W-1:0]         cur_next;
	logic [W-1:0]         total;
	logic [31:0]          value_d;

	ieval_pkg::unit_req_t unit_req;
	ieval_pkg::unit_rsp_t unit_rsp;
	logic [W-1:0]         unit_result;

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_digit  = s_tdata inside {[ieval_pkg::CharZero:ieval_pkg::CharNine]};
		in_op     = 1'b1;
		in_opcode = ieval_pkg::OP_PLUS;
		case (s_tdata)
			ieval_pkg::CharPlus:  in_opcode = ieval_pkg::OP_PLUS;
			ieval_pkg::CharMinus: in_opcode = ieval_pkg::OP_MINUS;
			ieval_pkg::CharStar:  in_opcode = ieval_pkg::OP_MUL;
			ieval_pkg::CharSlash: in_opcode = ieval_pkg::OP_DIV;
			default:              in_op = 1'b0;
		endcase
	end

	assign digit    = 4'(s_tdata - ieval_pkg::CharZero);
	assign cur_next = {cur_q[W-4:0], 3'b000} + {cur_q[W-2:0], 1'b0} + W'(digit);
	assign total    = sum_q + term_q;

	generate
		if (W >= ieval_pkg::ValueOutW) begin : g_trunc
			assign value_d = total[ieval_pkg::ValueOutW-1:0];
		end else begin : g_ext
			assign value_d = {{(ieval_pkg::ValueOutW - W){1'b0}}, total};
		end
	endgenerate

	assign unit_req.start  = (state_q == ST_RESOLVE) &&
		((op_q == ieval_pkg::OP_MUL) || (op_q == ieval_pkg::OP_DIV));
	assign unit_req.is_div = (op_q == ieval_pkg::OP_DIV);

	ieval_muldiv #(
		.W(W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.a      (term_q),
		.b      (cur_q),
		.rsp    (unit_rsp),
		.result (unit_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			term_q     <= '0;
			sum_q      <= '0;
			op_q       <= ieval_pkg::OP_PLUS;
			new_op_q   <= ieval_pkg::OP_PLUS;
			is_op_q    <= 1'b0;
			last_q     <= 1'b0;
			err_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_digit) begin
							cur_q <= cur_next;
						end
						new_op_q <= in_opcode;
						is_op_q  <= in_op;
						last_q   <= s_tlast;
						if (in_op || s_tlast) begin
							state_q <= ST_RESOLVE;
						end
					end
				end
				ST_RESOLVE: begin
					cur_q <= '0;
					case (op_q)
						ieval_pkg::OP_MUL, ieval_pkg::OP_DIV: begin
							state_q <= ST_WAIT;
						end
						ieval_pkg::OP_MINUS: begin
							sum_q   <= total;
							term_q  <= W'(0) - cur_q;
							state_q <= ST_FINISH;
						end
						default: begin
							sum_q   <= total;
							term_q  <= cur_q;
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_WAIT: begin
					if (unit_rsp.done) begin
						term_q  <= unit_result;
						err_q   <= err_q | unit_rsp.dbz;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (last_q) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= value_d;
						m_tuser_q  <= err_q;
						cur_q      <= '0;
						term_q     <= '0;
						sum_q      <= '0;
						op_q       <= ieval_pkg::OP_PLUS;
						err_q      <= 1'b0;
					end else if (is_op_q) begin
						op_q <= new_op_q;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		unit_rsp.done |-> (state_q == ST_WAIT))
		else $error("mul/div unit finished outside the wait state");

	a_emit_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FINISH) && $past(last_q))
		else $error("result item raised without a finished last character");

	a_cleared_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (sum_q == '0) && (term_q == '0) && (cur_q == '0) && !err_q)
		else $error("expression state not cleared after result");

endmodule

FILE: hdl/ieval_muldiv.sv
// iterative shared multiply / divide unit, one bit per cycle over one adder
// wrapping multiply and signed truncating divide; division by zero gives 0
// depends on ieval_pkg
module ieval_muldiv #(
	parameter int unsigned W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ieval_pkg::unit_req_t  req,
	input  logic [W-1:0]          a,
	input  logic [W-1:0]          b,
	output ieval_pkg::unit_rsp_t  rsp,
	output logic [W-1:0]          result
);

	localparam int unsigned CntW = $clog2(W);
	localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

	typedef enum logic [1:0] {
		U_IDLE,
		U_RUN,
		U_FIX
	} ustate_t;

	ustate_t        state_q;
	logic [CntW-1:0] cnt_q;
	logic           is_div_q;
	logic           neg_q;
	logic           done_q;
	logic           dbz_q;
	logic [W-1:0]   acc_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   dvs_q;
	logic [W-1:0]   result_q;

	logic [W+1:0]   add_x;
	logic [W+1:0]   add_y;
	logic           add_sub;
	logic [W+1:0]   add_sum;
	logic [W-1:0]   a_mag;
	logic [W-1:0]   b_mag;
	logic           div_neg;

	assign a_mag = a[W-1] ? (W'(0) - a) : a;
	assign b_mag = b[W-1] ? (W'(0) - b) : b;
	assign div_neg = add_sum[W+1];

	// the one shared adder
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			U_RUN: begin
				if (is_div_q) begin
					add_x   = {1'b0, acc_q, quo_q[W-1]};
					add_y   = {2'b00, dvs_q};
					add_sub = 1'b1;
				end else begin
					add_x   = {2'b00, acc_q};
					add_y   = {2'b00, dvs_q};
				end
			end
			U_FIX: begin
				add_y   = {2'b00, quo_q};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
		add_sum = add_x + (add_sub ? ~add_y : add_y) + (W+2)'(add_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= U_IDLE;
			cnt_q    <= '0;
			is_div_q <= 1'b0;
			neg_q    <= 1'b0;
			done_q   <= 1'b0;
			dbz_q    <= 1'b0;
			acc_q    <= '0;
			quo_q    <= '0;
			dvs_q    <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						is_div_q <= req.is_div;
						cnt_q    <= '0;
						acc_q    <= '0;
						if (req.is_div && (b == '0)) begin
							result_q <= '0;
							dbz_q    <= 1'b1;
							done_q   <= 1'b1;
						end else if (req.is_div) begin
							dbz_q   <= 1'b0;
							quo_q   <= a_mag;
							dvs_q   <= b_mag;
							neg_q   <= a[W-1] ^ b[W-1];
							state_q <= U_RUN;
						end else begin
							dbz_q   <= 1'b0;
							quo_q   <= b;
							dvs_q   <= a;
							state_q <= U_RUN;
						end
					end
				end
				U_RUN: begin
					cnt_q <= cnt_q + CntW'(1);
					if (is_div_q) begin
						acc_q <= div_neg ? {acc_q[W-2:0], quo_q[W-1]} : add_sum[W-1:0];
						quo_q <= {quo_q[W-2:0], ~div_neg};
					end else begin
						// quo holds the multiplier, dvs the shifted multiplicand
						if (quo_q[0]) begin
							acc_q <= add_sum[W-1:0];
						end
						quo_q <= {1'b0, quo_q[W-1:1]};
						dvs_q <= {dvs_q[W-2:0], 1'b0};
					end
					if (cnt_q == CntLast) begin
						state_q <= U_FIX;
					end
				end
				U_FIX: begin
					if (is_div_q) begin
						result_q <= neg_q ? add_sum[W-1:0] : quo_q;
					end else begin
						result_q <= acc_q;
					end
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.dbz  = dbz_q;
	assign result   = result_q;

endmodule

FILE: test/tb_top.sv
// testbench for infix_expression_evaluator_core: streams expression characters, predicts
// each value and divide-by-zero flag in its own model and compares them with the results
// depends on ieval_pkg and the evaluator rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} char_item_t;

	typedef struct {
		logic [31:0] value;
		logic        dbz;
	} calc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // char_code
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // value
	logic        m_tuser;          // div_by_zero

	char_item_t   char_q[$];
	char_item_t   expr_q[$];
	calc_result_t value_q[$];

	// expression state of the predictor
	logic [31:0]    num_acc;
	logic [31:0]    term_acc;
	logic [31:0]    sum_acc;
	ieval_pkg::op_t op_pending;
	logic           dbz_seen;

	int errors = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	int useful_cnt = 0;

	infix_expression_evaluator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 50);
	endfunction

	function automatic logic [7:0] op_char(ieval_pkg::op_t op);
		case (op)
			ieval_pkg::OP_PLUS:  return ieval_pkg::CharPlus;
			ieval_pkg::OP_MINUS: return ieval_pkg::CharMinus;
			ieval_pkg::OP_MUL:   return ieval_pkg::CharStar;
			default:             return ieval_pkg::CharSlash;
		endcase
	endfunction

	function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		if (b == 32'd0)
			return 32'd0;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		if (a[31] != b[31])
			q = -q;
		return q;
	endfunction

	task automatic clear_expr();
		num_acc = 32'd0;
		term_acc = 32'd0;
		sum_acc = 32'd0;
		op_pending = ieval_pkg::OP_PLUS;
		dbz_seen = 1'b0;
	endtask

	task automatic fold_number();
		case (op_pending)
			ieval_pkg::OP_MUL: term_acc = term_acc * num_acc;
			ieval_pkg::OP_DIV: begin
				if (num_acc == 32'd0)
					dbz_seen = 1'b1;
				term_acc = trunc_quotient(term_acc, num_acc);
			end
			ieval_pkg::OP_MINUS: begin
				sum_acc = sum_acc + term_acc;
				term_acc = -num_acc;
			end
			default: begin
				sum_acc = sum_acc + term_acc;
				term_acc = num_acc;
			end
		endcase
		num_acc = 32'd0;
	endtask

	task automatic predict_char(input logic [7:0] code, input logic last);
		ieval_pkg::op_t new_op;
		logic           is_op;
		calc_result_t   res;
		is_op = 1'b1;
		new_op = ieval_pkg::OP_PLUS;
		if (code >= ieval_pkg::CharZero && code <= ieval_pkg::CharNine) begin
			num_acc = num_acc * 32'd10 + {24'd0, code - ieval_pkg::CharZero};
			is_op = 1'b0;
		end else if (code == ieval_pkg::CharPlus) begin
			new_op = ieval_pkg::OP_PLUS;
		end else if (code == ieval_pkg::CharMinus) begin
			new_op = ieval_pkg::OP_MINUS;
		end else if (code == ieval_pkg::CharStar) begin
			new_op = ieval_pkg::OP_MUL;
		end else if (code == ieval_pkg::CharSlash) begin
			new_op = ieval_pkg::OP_DIV;
		end else begin
			is_op = 1'b0;
		end
		if (is_op || last)
			fold_number();
		if (is_op)
			op_pending = new_op;
		if (last) begin
			res.value = sum_acc + term_acc;
			res.dbz = dbz_seen;
			value_q.push_back(res);
			clear_expr();
		end
	endtask

	// stimulus building: characters collect in expr_q, the last one gets tlast
	task automatic add_char(input logic [7:0] code);
		char_item_t it;
		it.code = code;
		it.last = 1'b0;
		expr_q.push_back(it);
		if ((code >= ieval_pkg::CharZero && code <= ieval_pkg::CharNine) ||
				code == ieval_pkg::CharPlus || code == ieval_pkg::CharMinus ||
				code == ieval_pkg::CharStar || code == ieval_pkg::CharSlash)
			useful_cnt++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic close_expr();
		char_item_t it;
		expr_q[expr_q.size() - 1].last = 1'b1;
		while (expr_q.size() != 0) begin
			it = expr_q.pop_front();
			char_q.push_back(it);
		end
	endtask

	task automatic maybe_space();
		if ($urandom_range(0, 9) == 0)
			add_char(8'h20);
	endtask

	task automatic add_number();
		int r;
		int nd;
		r = $urandom_range(0, 99);
		if (r < 8)
			nd = $urandom_range(10, 11);
		else if (r < 16)
			nd = 0;
		else
			nd = $urandom_range(1, 3);
		if (nd == 0)
			add_char(ieval_pkg::CharZero);
		for (int i = 0; i < nd; i++)
			add_char(ieval_pkg::CharZero + 8'($urandom_range(0, 9)));
		maybe_space();
	endtask

	task automatic add_random_op();
		add_char(op_char(ieval_pkg::op_t'($urandom_range(0, 3))));
		maybe_space();
	endtask

	task automatic gen_expression();
		int kind;
		int n;
		int r;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			if ($urandom_range(0, 6) == 0)
				add_random_op();
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					add_random_op();
				add_number();
			end
			r = $urandom_range(0, 9);
			if (r == 0)
				add_random_op();
			else if (r == 1)
				add_char(8'h20);
		end else if (kind < 76) begin
			// most negative value divided by minus one
			add_text("-2147483648/4294967295");
			if ($urandom_range(0, 1) == 0) begin
				add_random_op();
				add_number();
			end
		end else if (kind < 82) begin
			add_number();
			add_random_op();
			add_random_op();
			add_number();
		end else begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 2);
				if (r == 0)
					add_char(ieval_pkg::CharZero + 8'($urandom_range(0, 9)));
				else if (r == 1)
					add_char(op_char(ieval_pkg::op_t'($urandom_range(0, 3))));
				else
					add_char(8'($urandom_range(0, 255)));
			end
		end
		close_expr();
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		char_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tlast <= 1'b0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_char(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (char_q.size() != 0) begin
					it = char_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.code;
					s_tlast <= it.last;
					tx_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen == 30) begin
			hold_left <= 3000;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		calc_result_t exp_res;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (value_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: value %0d dbz %0b",
							$signed(m_tdata), m_tuser);
					errors++;
				end else begin
					exp_res = value_q.pop_front();
					if (m_tdata !== exp_res.value || m_tuser !== exp_res.dbz) begin
						if (errors < 10)
							$display("mismatch: expected value %0d dbz %0b, got value %0d dbz %0b",
								$signed(exp_res.value), exp_res.dbz, $signed(m_tdata), m_tuser);
						errors++;
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (hold_left == 0);
				rx_stall = pick_gap();
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		clear_expr();
		// directed expressions
		add_text("3+4*2");
		close_expr();
		add_text("8/0");
		close_expr();
		add_text("-8/3");
		close_expr();
		add_text("5*-");
		close_expr();
		add_char(8'h00);
		add_char(8'hff);
		close_expr();
		add_char(8'h20);
		close_expr();
		add_text("9-");
		close_expr();
		while (useful_cnt < 1000)
			gen_expression();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (value_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/ieval_pkg.sv
hdl/ieval_muldiv.sv
hdl/infix_expression_evaluator_core.sv
test/tb_top.sv
